### hw/rtl/mesh_vertex_normal_engine_defines.svh
// ----------------------------------------------------------------------------
// Mesh vertex normal engine: assertion macros
// Concurrent property shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MESH_VERTEX_NORMAL_ENGINE_DEFINES_SVH
`define MESH_VERTEX_NORMAL_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MVN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("property violated");

// next-cycle implication, disabled in reset
`define MVN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("property violated");

`endif

### hw/rtl/mvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex normal engine package
// Field widths, operation codes, payload types and controller commands.
// ----------------------------------------------------------------------------
package mvn_pkg;

  localparam int VERTICES_DEF = 1024;
  localparam int SUM_BITS_DEF = 48;
  localparam int COORD_BITS   = 20;
  localparam int NORMAL_BITS  = 16;
  localparam int INDEX_BITS   = 10;
  localparam int OP_BITS      = 2;
  localparam int CC_BITS      = 4;

  localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_READ  = 2'd2;
  localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;

  localparam logic [CC_BITS-1:0] CELL_CORNERS = 4'd3;

  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]           op;
    logic [INDEX_BITS-1:0]        index_a;
    logic [INDEX_BITS-1:0]        index_b;
    logic [INDEX_BITS-1:0]        index_c;
    logic [CC_BITS-1:0]           corner_count;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]         vertex;
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    logic                          degenerate;
    logic                          saturated;
  } result_t;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_PRD_A,
    CMD_PRD_B,
    CMD_PRD_C,
    CMD_WDIFF,
    CMD_MUL,
    CMD_SRD,
    CMD_SWR,
    CMD_NLATCH,
    CMD_SQ,
    CMD_TOTAL,
    CMD_SINIT,
    CMD_SRCH,
    CMD_SSTORE,
    CMD_EMIT
  } dp_cmd_e;

  typedef struct packed {
    logic       take;
    dp_cmd_e    cmd;
    logic [1:0] sel;
  } dp_ctrl_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               a_ok;
    logic               add_ok;
    logic               zero;
    logic               clr_last;
    logic               mul_last;
    logic               sq_last;
    logic               srch_last;
  } dp_stat_t;

endpackage

### hw/rtl/mvn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex normal engine controller
// Sequences clearing, loads, cell accumulation and normal reads.
// ----------------------------------------------------------------------------
module mvn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mvn_pkg::dp_stat_t stat_i,
  output mvn_pkg::dp_ctrl_t ctrl_o
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_PRD_A,
    S_PRD_B,
    S_PRD_C,
    S_WDIFF,
    S_MUL,
    S_SRD,
    S_SWR,
    S_RSRD,
    S_NLATCH,
    S_SQ,
    S_TOTAL,
    S_SINIT,
    S_SRCH,
    S_SSTORE,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  mvn_pkg::dp_cmd_e cmd_q, cmd_d;
  logic [1:0]       sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    sel_d   = sel_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
          cmd_d   = mvn_pkg::CMD_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_DECODE;
          cmd_d   = mvn_pkg::CMD_IDLE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        cmd_d   = mvn_pkg::CMD_IDLE;
        case (stat_i.op)
          mvn_pkg::OP_LOAD: begin
            if (stat_i.a_ok) begin
              state_d = S_LOAD;
              cmd_d   = mvn_pkg::CMD_LOAD;
            end
          end
          mvn_pkg::OP_ADD: begin
            if (stat_i.add_ok) begin
              state_d = S_PRD_A;
              cmd_d   = mvn_pkg::CMD_PRD_A;
            end
          end
          mvn_pkg::OP_READ: begin
            if (stat_i.a_ok) begin
              state_d = S_RSRD;
              cmd_d   = mvn_pkg::CMD_SRD;
              sel_d   = mvn_pkg::CORNER_A;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_LOAD: begin
        state_d = S_IDLE;
        cmd_d   = mvn_pkg::CMD_IDLE;
      end
      S_PRD_A: begin
        state_d = S_PRD_B;
        cmd_d   = mvn_pkg::CMD_PRD_B;
      end
      S_PRD_B: begin
        state_d = S_PRD_C;
        cmd_d   = mvn_pkg::CMD_PRD_C;
      end
      S_PRD_C: begin
        state_d = S_WDIFF;
        cmd_d   = mvn_pkg::CMD_WDIFF;
      end
      S_WDIFF: begin
        state_d = S_MUL;
        cmd_d   = mvn_pkg::CMD_MUL;
      end
      S_MUL: begin
        if (stat_i.mul_last) begin
          state_d = S_SRD;
          cmd_d   = mvn_pkg::CMD_SRD;
          sel_d   = mvn_pkg::CORNER_A;
        end
      end
      S_SRD: begin
        state_d = S_SWR;
        cmd_d   = mvn_pkg::CMD_SWR;
      end
      S_SWR: begin
        if (sel_q == mvn_pkg::CORNER_C) begin
          state_d = S_IDLE;
          cmd_d   = mvn_pkg::CMD_IDLE;
        end else begin
          state_d = S_SRD;
          cmd_d   = mvn_pkg::CMD_SRD;
          sel_d   = sel_q + 2'd1;
        end
      end
      S_RSRD: begin
        state_d = S_NLATCH;
        cmd_d   = mvn_pkg::CMD_NLATCH;
      end
      S_NLATCH: begin
        if (stat_i.zero) begin
          state_d = S_EMIT;
          cmd_d   = mvn_pkg::CMD_EMIT;
        end else begin
          state_d = S_SQ;
          cmd_d   = mvn_pkg::CMD_SQ;
        end
      end
      S_SQ: begin
        if (stat_i.sq_last) begin
          state_d = S_TOTAL;
          cmd_d   = mvn_pkg::CMD_TOTAL;
        end
      end
      S_TOTAL: begin
        state_d = S_SINIT;
        cmd_d   = mvn_pkg::CMD_SINIT;
        sel_d   = mvn_pkg::CORNER_A;
      end
      S_SINIT: begin
        state_d = S_SRCH;
        cmd_d   = mvn_pkg::CMD_SRCH;
      end
      S_SRCH: begin
        if (stat_i.srch_last) begin
          state_d = S_SSTORE;
          cmd_d   = mvn_pkg::CMD_SSTORE;
        end
      end
      S_SSTORE: begin
        if (sel_q == mvn_pkg::CORNER_C) begin
          state_d = S_EMIT;
          cmd_d   = mvn_pkg::CMD_EMIT;
        end else begin
          state_d = S_SINIT;
          cmd_d   = mvn_pkg::CMD_SINIT;
          sel_d   = sel_q + 2'd1;
        end
      end
      S_EMIT: begin
        state_d = S_IDLE;
        cmd_d   = mvn_pkg::CMD_IDLE;
      end
      default: begin
        state_d = S_IDLE;
        cmd_d   = mvn_pkg::CMD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cmd_q   <= mvn_pkg::CMD_CLEAR;
      sel_q   <= mvn_pkg::CORNER_A;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      sel_q   <= sel_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign ctrl_o.take = (state_q == S_IDLE) && start;
  assign ctrl_o.cmd  = cmd_q;
  assign ctrl_o.sel  = sel_q;

endmodule

### hw/rtl/mvn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex normal engine datapath
// Position and sum memories, face vector unit, saturating accumulate,
// bit-serial squares and a shift-add normalization search.
// ----------------------------------------------------------------------------
module mvn_datapath #(
  parameter int VERTICES = mvn_pkg::VERTICES_DEF,
  parameter int SUM_BITS = mvn_pkg::SUM_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mvn_pkg::item_t    item_i,
  input  mvn_pkg::dp_ctrl_t ctrl_i,
  output mvn_pkg::dp_stat_t stat_o,
  output mvn_pkg::result_t  result_o,
  output logic              done_o
);

  localparam int ADDR_BITS = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int CB        = mvn_pkg::COORD_BITS;
  localparam int NB        = mvn_pkg::NORMAL_BITS;
  localparam int DIFF_BITS = CB + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int FACE_BITS = PROD_BITS + 1;
  localparam int ACC_BITS  = ((SUM_BITS > FACE_BITS) ? SUM_BITS : FACE_BITS) + 1;
  localparam int SQ_BITS   = 2 * SUM_BITS;
  localparam int TOT_BITS  = SQ_BITS + 2;
  localparam int TW        = TOT_BITS + 2 * NB;
  localparam int SQC_BITS  = $clog2(SUM_BITS);
  localparam int KB        = $clog2(NB);

  localparam logic signed [ACC_BITS-1:0] SUM_MAX =
    {{(ACC_BITS - SUM_BITS + 1){1'b0}}, {(SUM_BITS - 1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic [NB-1:0] Q_MAX = {1'b0, {(NB - 1){1'b1}}};

  mvn_pkg::item_t item_q;

  logic signed [CB-1:0] pos_x_mem [VERTICES];
  logic signed [CB-1:0] pos_y_mem [VERTICES];
  logic signed [CB-1:0] pos_z_mem [VERTICES];
  logic signed [SUM_BITS-1:0] sum_x_mem [VERTICES];
  logic signed [SUM_BITS-1:0] sum_y_mem [VERTICES];
  logic signed [SUM_BITS-1:0] sum_z_mem [VERTICES];
  logic sat_mem [VERTICES];

  logic [ADDR_BITS-1:0] clr_addr_q;
  logic [ADDR_BITS-1:0] a_addr, prd_addr, corner_addr, sum_waddr;
  logic [mvn_pkg::INDEX_BITS-1:0] corner_idx, prd_idx;

  logic signed [CB-1:0]        pos_rd_q [3];
  logic signed [CB-1:0]        v0_q [3];
  logic signed [DIFF_BITS-1:0] u_q [3];
  logic signed [DIFF_BITS-1:0] w_q [3];
  logic signed [DIFF_BITS-1:0] mul_a, mul_b;
  logic signed [PROD_BITS-1:0] mul_p, prod_q;
  logic signed [FACE_BITS-1:0] face_q [3];
  logic [2:0]                  mstep_q;

  logic signed [SUM_BITS-1:0] sum_rd_q [3];
  logic                       sat_rd_q;
  logic signed [SUM_BITS-1:0] sum_wdata [3];
  logic signed [SUM_BITS-1:0] sum_new [3];
  logic                       sat_flag [3];
  logic                       sat_wdata;
  logic                       sum_we;
  logic signed [ACC_BITS-1:0] acc_sum [3];

  logic [SUM_BITS-1:0] mag [3];
  logic [SQ_BITS-1:0]  mc_q [3];
  logic [SUM_BITS-1:0] mp_q [3];
  logic [SQ_BITS-1:0]  sq_q [3];
  logic [SQC_BITS-1:0] sqc_q;
  logic [TOT_BITS-1:0] tot_q;
  logic                neg_q [3];

  logic [TW-1:0] t_q, g_q, d_q, rhs_q, ct_q, cg_q;
  logic [KB-1:0] k_q;
  logic          ph_q;
  logic [NB-1:0] qv_q, qc;
  logic signed [NB-1:0] nv;

  mvn_pkg::result_t res_q;
  logic             done_q;
  logic             a_ok, b_ok, c_ok;

  assign a_ok = 32'(item_q.index_a) < VERTICES;
  assign b_ok = 32'(item_q.index_b) < VERTICES;
  assign c_ok = 32'(item_q.index_c) < VERTICES;

  always_comb begin
    case (ctrl_i.sel)
      mvn_pkg::CORNER_A: corner_idx = item_q.index_a;
      mvn_pkg::CORNER_B: corner_idx = item_q.index_b;
      default:           corner_idx = item_q.index_c;
    endcase
    case (ctrl_i.cmd)
      mvn_pkg::CMD_PRD_B: prd_idx = item_q.index_b;
      mvn_pkg::CMD_PRD_C: prd_idx = item_q.index_c;
      default:            prd_idx = item_q.index_a;
    endcase
  end

  assign a_addr      = ADDR_BITS'(item_q.index_a);
  assign prd_addr    = ADDR_BITS'(prd_idx);
  assign corner_addr = ADDR_BITS'(corner_idx);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (ctrl_i.cmd == mvn_pkg::CMD_CLEAR) begin
      clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == mvn_pkg::CMD_LOAD) begin
      pos_x_mem[a_addr] <= item_q.x;
      pos_y_mem[a_addr] <= item_q.y;
      pos_z_mem[a_addr] <= item_q.z;
    end
    pos_rd_q[0] <= pos_x_mem[prd_addr];
    pos_rd_q[1] <= pos_y_mem[prd_addr];
    pos_rd_q[2] <= pos_z_mem[prd_addr];
  end

  always_comb begin
    case (mstep_q)
      3'd0:    begin mul_a = u_q[1]; mul_b = w_q[2]; end
      3'd1:    begin mul_a = u_q[2]; mul_b = w_q[1]; end
      3'd2:    begin mul_a = u_q[2]; mul_b = w_q[0]; end
      3'd3:    begin mul_a = u_q[0]; mul_b = w_q[2]; end
      3'd4:    begin mul_a = u_q[0]; mul_b = w_q[1]; end
      3'd5:    begin mul_a = u_q[1]; mul_b = w_q[0]; end
      default: begin mul_a = u_q[0]; mul_b = w_q[0]; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      mvn_pkg::CMD_PRD_B: begin
        for (int i = 0; i < 3; i++) begin
          v0_q[i] <= pos_rd_q[i];
        end
      end
      mvn_pkg::CMD_PRD_C: begin
        for (int i = 0; i < 3; i++) begin
          u_q[i] <= DIFF_BITS'(pos_rd_q[i]) - DIFF_BITS'(v0_q[i]);
        end
      end
      mvn_pkg::CMD_WDIFF: begin
        for (int i = 0; i < 3; i++) begin
          w_q[i] <= DIFF_BITS'(pos_rd_q[i]) - DIFF_BITS'(v0_q[i]);
        end
      end
      mvn_pkg::CMD_MUL: begin
        prod_q <= mul_p;
        case (mstep_q)
          3'd1:    face_q[0] <= FACE_BITS'(prod_q);
          3'd2:    face_q[0] <= face_q[0] - FACE_BITS'(prod_q);
          3'd3:    face_q[1] <= FACE_BITS'(prod_q);
          3'd4:    face_q[1] <= face_q[1] - FACE_BITS'(prod_q);
          3'd5:    face_q[2] <= FACE_BITS'(prod_q);
          3'd6:    face_q[2] <= face_q[2] - FACE_BITS'(prod_q);
          default: face_q[0] <= face_q[0];
        endcase
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstep_q <= '0;
    end else if (ctrl_i.cmd == mvn_pkg::CMD_WDIFF) begin
      mstep_q <= '0;
    end else if (ctrl_i.cmd == mvn_pkg::CMD_MUL) begin
      mstep_q <= mstep_q + 3'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_sum[i] = ACC_BITS'(sum_rd_q[i]) + ACC_BITS'(face_q[i]);
      if (acc_sum[i] > SUM_MAX) begin
        sum_new[i]  = SUM_MAX[SUM_BITS-1:0];
        sat_flag[i] = 1'b1;
      end else if (acc_sum[i] < SUM_MIN) begin
        sum_new[i]  = SUM_MIN[SUM_BITS-1:0];
        sat_flag[i] = 1'b1;
      end else begin
        sum_new[i]  = acc_sum[i][SUM_BITS-1:0];
        sat_flag[i] = 1'b0;
      end
    end
  end

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = a_addr;
    sat_wdata = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum_wdata[i] = '0;
    end
    case (ctrl_i.cmd)
      mvn_pkg::CMD_CLEAR: begin
        sum_we    = 1'b1;
        sum_waddr = clr_addr_q;
      end
      mvn_pkg::CMD_LOAD: begin
        sum_we = 1'b1;
      end
      mvn_pkg::CMD_SWR: begin
        sum_we    = 1'b1;
        sum_waddr = corner_addr;
        sat_wdata = sat_rd_q | sat_flag[0] | sat_flag[1] | sat_flag[2];
        for (int i = 0; i < 3; i++) begin
          sum_wdata[i] = sum_new[i];
        end
      end
      default: begin
        sum_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_x_mem[sum_waddr] <= sum_wdata[0];
      sum_y_mem[sum_waddr] <= sum_wdata[1];
      sum_z_mem[sum_waddr] <= sum_wdata[2];
      sat_mem[sum_waddr]   <= sat_wdata;
    end
    sum_rd_q[0] <= sum_x_mem[corner_addr];
    sum_rd_q[1] <= sum_y_mem[corner_addr];
    sum_rd_q[2] <= sum_z_mem[corner_addr];
    sat_rd_q    <= sat_mem[corner_addr];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = sum_rd_q[i][SUM_BITS-1] ? SUM_BITS'(-sum_rd_q[i]) : SUM_BITS'(sum_rd_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      mvn_pkg::CMD_NLATCH: begin
        for (int i = 0; i < 3; i++) begin
          mc_q[i]  <= SQ_BITS'(mag[i]);
          mp_q[i]  <= mag[i];
          sq_q[i]  <= '0;
          neg_q[i] <= sum_rd_q[i][SUM_BITS-1];
        end
      end
      mvn_pkg::CMD_SQ: begin
        for (int i = 0; i < 3; i++) begin
          if (mp_q[i][0]) begin
            sq_q[i] <= sq_q[i] + mc_q[i];
          end
          mc_q[i] <= mc_q[i] << 1;
          mp_q[i] <= mp_q[i] >> 1;
        end
      end
      mvn_pkg::CMD_TOTAL: begin
        tot_q <= TOT_BITS'(sq_q[0]) + TOT_BITS'(sq_q[1]) + TOT_BITS'(sq_q[2]);
      end
      default: begin
        tot_q <= tot_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqc_q <= '0;
    end else if (ctrl_i.cmd == mvn_pkg::CMD_NLATCH) begin
      sqc_q <= '0;
    end else if (ctrl_i.cmd == mvn_pkg::CMD_SQ) begin
      sqc_q <= sqc_q + SQC_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      mvn_pkg::CMD_SINIT: begin
        t_q   <= '0;
        g_q   <= '0;
        qv_q  <= '0;
        d_q   <= TW'(tot_q) << (2 * NB - 2);
        rhs_q <= TW'(sq_q[ctrl_i.sel]) << (2 * NB - 2);
      end
      mvn_pkg::CMD_SRCH: begin
        if (!ph_q) begin
          ct_q <= t_q + g_q + d_q;
          cg_q <= g_q + (d_q << 1);
        end else begin
          if (ct_q <= rhs_q) begin
            t_q        <= ct_q;
            g_q        <= cg_q >> 1;
            qv_q[k_q]  <= 1'b1;
          end else begin
            g_q <= g_q >> 1;
          end
          d_q <= d_q >> 2;
        end
      end
      default: begin
        t_q <= t_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      ph_q <= 1'b0;
    end else if (ctrl_i.cmd == mvn_pkg::CMD_SINIT) begin
      k_q  <= KB'(NB - 1);
      ph_q <= 1'b0;
    end else if (ctrl_i.cmd == mvn_pkg::CMD_SRCH) begin
      ph_q <= ~ph_q;
      if (ph_q) begin
        k_q <= k_q - KB'(1);
      end
    end
  end

  assign qc = qv_q[NB-1] ? Q_MAX : qv_q;
  assign nv = neg_q[ctrl_i.sel] ? NB'(-qc) : NB'(qc);

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      mvn_pkg::CMD_NLATCH: begin
        res_q.vertex     <= item_q.index_a;
        res_q.normal_x   <= '0;
        res_q.normal_y   <= '0;
        res_q.normal_z   <= '0;
        res_q.degenerate <= stat_o.zero;
        res_q.saturated  <= sat_rd_q;
      end
      mvn_pkg::CMD_SSTORE: begin
        case (ctrl_i.sel)
          mvn_pkg::CORNER_A: res_q.normal_x <= nv;
          mvn_pkg::CORNER_B: res_q.normal_y <= nv;
          default:           res_q.normal_z <= nv;
        endcase
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (ctrl_i.cmd == mvn_pkg::CMD_EMIT);
    end
  end

  assign stat_o.op        = item_q.op;
  assign stat_o.a_ok      = a_ok;
  assign stat_o.add_ok    = a_ok && b_ok && c_ok &&
                            (item_q.corner_count == mvn_pkg::CELL_CORNERS);
  assign stat_o.zero      = (sum_rd_q[0] == '0) && (sum_rd_q[1] == '0) &&
                            (sum_rd_q[2] == '0);
  assign stat_o.clr_last  = (clr_addr_q == ADDR_BITS'(VERTICES - 1));
  assign stat_o.mul_last  = (mstep_q == 3'd6);
  assign stat_o.sq_last   = (sqc_q == SQC_BITS'(SUM_BITS - 1));
  assign stat_o.srch_last = ph_q && (k_q == '0);

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

### hw/rtl/mesh_vertex_normal_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex normal engine
// Items: load a position, add a cell, or read a normal, which takes a shorter
// path for a zero sum; a read strobes its result on done_o as it ends. One
// item at a time; results cannot be stalled. After reset busy stays high
// while the sum store clears.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_engine #(
  parameter int VERTICES = mvn_pkg::VERTICES_DEF,
  parameter int SUM_BITS = mvn_pkg::SUM_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  mvn_pkg::item_t   item_i,
  output mvn_pkg::result_t result_o,
  output logic             done_o
);

  mvn_pkg::dp_ctrl_t ctrl;
  mvn_pkg::dp_stat_t stat;

  mvn_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  mvn_datapath #(
    .VERTICES (VERTICES),
    .SUM_BITS (SUM_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .result_o (result_o),
    .done_o   (done_o)
  );

endmodule

### hw/rtl/mvn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex normal engine port checker
// Watches the top-level ports for transfer and result ordering rules.
// ----------------------------------------------------------------------------
`include "mesh_vertex_normal_engine_defines.svh"

module mvn_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input mvn_pkg::item_t   item_i,
  input mvn_pkg::result_t result_o,
  input logic             done_o
);

  `MVN_ASSERT_NXT(a_take_busy, clk_i, rst_ni, start && !busy, busy)
  `MVN_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  `MVN_ASSERT_IMP(a_done_after_work, clk_i, rst_ni, done_o, $past(busy))
  `MVN_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, done_o && result_o.degenerate, (result_o.normal_x == '0) && (result_o.normal_y == '0) && (result_o.normal_z == '0))

endmodule

bind mesh_vertex_normal_engine mvn_checker u_mvn_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .result_o (result_o),
  .done_o   (done_o)
);
